/* design/rob_pkg.sv */
// ----------------------------------------------------------------------------
// rob_pkg
// Shared codes and control types for the in-order release reorder buffer.
// ----------------------------------------------------------------------------
package rob_pkg;

  localparam int KIND_W   = 3;
  localparam int CREDIT_W = 5;
  localparam int TOTAL_W  = 32;
  localparam int CFG_AW   = 3;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_GRANT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HOLD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROP    = 3'd4;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_DELIVER = 1'b1;

  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_PENDING = 1'b1;

  // hold store access requests from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic pop;
  } st_ctl_t;

endpackage

/* design/rob_if.sv */
// ----------------------------------------------------------------------------
// rob_in_if / rob_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface rob_in_if #(
  parameter int SEQ_BITS = 32,
  parameter int TAG_BITS = 16
);
  logic                valid;
  logic                ready;
  logic                command;
  logic [SEQ_BITS-1:0] seq_number;
  logic [TAG_BITS-1:0] item_handle;

  modport source (output valid, command, seq_number, item_handle, input ready);
  modport sink   (input valid, command, seq_number, item_handle, output ready);
endinterface

interface rob_out_if #(
  parameter int SEQ_BITS = 32,
  parameter int TAG_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic [SEQ_BITS-1:0] out_seq;
  logic [TAG_BITS-1:0] out_handle;
  logic [31:0]         released_total;
  logic                last;

  modport source (output valid, kind, out_seq, out_handle, released_total, last,
                  input ready);
  modport sink   (input valid, kind, out_seq, out_handle, released_total, last,
                  output ready);
endinterface

/* design/rob_cfg.sv */
// ----------------------------------------------------------------------------
// rob_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module rob_cfg
  import rob_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic              mode,
  output logic [3:0]        max_pending_next,
  output logic              cfg_wr
);

  logic       reg_sel;
  logic [3:0] max_pending;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;

  // limit as it stands after this beat, so a credit reload sees the new value
  always_comb begin
    max_pending_next = max_pending;
    if (cfg_wr && (reg_sel == REG_PENDING)) max_pending_next = pwdata[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b1;
      max_pending <= 4'd15;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MODE:    mode        <= pwdata[0];
        REG_PENDING: max_pending <= pwdata[3:0];
        default:     mode        <= mode;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE:    prdata = {31'd0, mode};
      REG_PENDING: prdata = {28'd0, max_pending};
      default:     prdata = '0;
    endcase
  end

endmodule

/* design/rob_store.sv */
// ----------------------------------------------------------------------------
// rob_store
// Sorted hold store kept as a ring in memory, addressed by position from head.
// ----------------------------------------------------------------------------
module rob_store
  import rob_pkg::*;
#(
  parameter int HOLD_DEPTH = 16,
  parameter int SEQ_BITS   = 32,
  parameter int TAG_BITS   = 16,
  parameter int IDX_W      = $clog2(HOLD_DEPTH)
)(
  input  logic                clk,
  input  logic                rst,
  input  st_ctl_t             ctl,
  input  logic [IDX_W-1:0]    rd_idx,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [SEQ_BITS-1:0] wr_seq,
  input  logic [TAG_BITS-1:0] wr_tag,
  output logic [SEQ_BITS-1:0] rd_seq,
  output logic [TAG_BITS-1:0] rd_tag
);

  localparam logic [IDX_W:0] DEPTH_V = (IDX_W+1)'(HOLD_DEPTH);

  logic [SEQ_BITS-1:0] mem_seq [HOLD_DEPTH];
  logic [TAG_BITS-1:0] mem_tag [HOLD_DEPTH];
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    rd_phys;
  logic [IDX_W-1:0]    wr_phys;
  logic [IDX_W-1:0]    head_next;

  function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_V) sum = sum - DEPTH_V;
    return sum[IDX_W-1:0];
  endfunction

  assign rd_phys   = ring(head, rd_idx);
  assign wr_phys   = ring(head, wr_idx);
  assign head_next = ring(head, IDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (ctl.pop) begin
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_seq[wr_phys] <= wr_seq;
      mem_tag[wr_phys] <= wr_tag;
    end
    if (ctl.rd_en) begin
      rd_seq <= mem_seq[rd_phys];
      rd_tag <= mem_tag[rd_phys];
    end
  end

endmodule

/* design/rob_seq.sv */
// ----------------------------------------------------------------------------
// rob_seq
// Sequencer: admission credits, sorted insertion walk and in-order drain.
// ----------------------------------------------------------------------------
module rob_seq
  import rob_pkg::*;
#(
  parameter int HOLD_DEPTH = 16,
  parameter int SEQ_BITS   = 32,
  parameter int TAG_BITS   = 16,
  parameter int IDX_W      = $clog2(HOLD_DEPTH),
  parameter int CNT_W      = $clog2(HOLD_DEPTH + 1)
)(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [SEQ_BITS-1:0] seq_number,
  input  logic [TAG_BITS-1:0] item_handle,
  input  logic                mode,
  input  logic [3:0]          max_pending,
  input  logic                cfg_wr,
  input  logic                emit_ok,
  output logic                emit_valid,
  output logic [KIND_W-1:0]   emit_kind,
  output logic [SEQ_BITS-1:0] emit_seq,
  output logic [TAG_BITS-1:0] emit_tag,
  output logic [TOTAL_W-1:0]  emit_total,
  output logic                emit_last,
  output st_ctl_t             st_ctl,
  output logic [IDX_W-1:0]    rd_idx,
  output logic [IDX_W-1:0]    wr_idx,
  output logic [SEQ_BITS-1:0] wr_seq,
  output logic [TAG_BITS-1:0] wr_tag,
  input  logic [SEQ_BITS-1:0] rd_seq,
  input  logic [TAG_BITS-1:0] rd_tag
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HOLD_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_ONE     = 5'b00010,
    S_INS_CMP = 5'b00100,
    S_INS_PUT = 5'b01000,
    S_DRN_CMP = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [SEQ_BITS-1:0]  next_exp, next_exp_next;
  logic [CREDIT_W-1:0]  credits, credits_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [TOTAL_W-1:0]   rel_cnt, rel_cnt_next;
  logic [IDX_W-1:0]     ins_idx, ins_idx_next;
  logic [SEQ_BITS-1:0]  cur_seq, cur_seq_next;
  logic [TAG_BITS-1:0]  cur_tag, cur_tag_next;
  logic [KIND_W-1:0]    res_kind, res_kind_next;
  logic                 in_fire;
  logic                 head_match;
  logic                 held_greater;
  logic                 is_release;
  logic                 add_credit;
  logic [CREDIT_W-1:0]  credit_inc;

  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid & in_ready;
  // drain compares the head with the expected number; the walk compares a held entry with the new item
  assign head_match   = (rd_seq == next_exp);
  assign held_greater = (rd_seq > cur_seq);
  assign credit_inc   = (credits == CREDIT_MAX) ? credits : credits + CREDIT_W'(1);

  always_comb begin
    state_next    = state;
    next_exp_next = next_exp;
    credits_next  = credits;
    count_next    = count;
    rel_cnt_next  = rel_cnt;
    ins_idx_next  = ins_idx;
    cur_seq_next  = cur_seq;
    cur_tag_next  = cur_tag;
    res_kind_next = res_kind;
    st_ctl        = '0;
    rd_idx        = '0;
    wr_idx        = ins_idx;
    wr_seq        = cur_seq;
    wr_tag        = cur_tag;
    emit_valid    = 1'b0;
    emit_kind     = res_kind;
    emit_seq      = cur_seq;
    emit_tag      = cur_tag;
    emit_last     = 1'b1;
    is_release    = 1'b0;
    add_credit    = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cur_seq_next = seq_number;
          cur_tag_next = item_handle;
          if (command == CMD_REQUEST) begin
            cur_seq_next = '0;
            cur_tag_next = '0;
            state_next   = S_ONE;
            if (!mode) begin
              res_kind_next = KIND_GRANT;
            end else if (credits != '0) begin
              res_kind_next = KIND_GRANT;
              credits_next  = credits - CREDIT_W'(1);
            end else begin
              res_kind_next = KIND_REFUSE;
            end
          end else if (!mode) begin
            res_kind_next = KIND_RELEASE;
            state_next    = S_ONE;
          end else if (seq_number == next_exp) begin
            next_exp_next = next_exp + SEQ_BITS'(1);
            if (count == '0) begin
              res_kind_next = KIND_RELEASE;
              state_next    = S_ONE;
            end else begin
              // fetch the head to see whether the drain goes on
              st_ctl.rd_en = 1'b1;
              rd_idx       = '0;
              state_next   = S_DRN_CMP;
            end
          end else if (count == DEPTH_C) begin
            res_kind_next = KIND_DROP;
            state_next    = S_ONE;
          end else if (count == '0) begin
            ins_idx_next = '0;
            state_next   = S_INS_PUT;
          end else begin
            // walk down from the tail
            ins_idx_next = IDX_W'(count - CNT_W'(1));
            st_ctl.rd_en = 1'b1;
            rd_idx       = IDX_W'(count - CNT_W'(1));
            state_next   = S_INS_CMP;
          end
        end
      end

      S_ONE: begin
        if (emit_ok) begin
          emit_valid = 1'b1;
          is_release = (res_kind == KIND_RELEASE);
          add_credit = is_release & mode;
          state_next = S_IDLE;
        end
      end

      S_INS_CMP: begin
        if (held_greater) begin
          // shift the larger entry up one place
          st_ctl.wr_en = 1'b1;
          wr_idx       = ins_idx + IDX_W'(1);
          wr_seq       = rd_seq;
          wr_tag       = rd_tag;
          if (ins_idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            st_ctl.rd_en = 1'b1;
            rd_idx       = ins_idx - IDX_W'(1);
            ins_idx_next = ins_idx - IDX_W'(1);
          end
        end else begin
          ins_idx_next = ins_idx + IDX_W'(1);
          state_next   = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        if (emit_ok) begin
          st_ctl.wr_en = 1'b1;
          count_next   = count + CNT_W'(1);
          emit_valid   = 1'b1;
          emit_kind    = KIND_HOLD;
          state_next   = S_IDLE;
        end
      end

      S_DRN_CMP: begin
        if (emit_ok) begin
          emit_valid = 1'b1;
          emit_kind  = KIND_RELEASE;
          is_release = 1'b1;
          add_credit = 1'b1;
          if (head_match) begin
            // pending beat goes out, head becomes the pending one
            emit_last     = 1'b0;
            st_ctl.pop    = 1'b1;
            count_next    = count - CNT_W'(1);
            next_exp_next = next_exp + SEQ_BITS'(1);
            cur_seq_next  = rd_seq;
            cur_tag_next  = rd_tag;
            if (count > CNT_W'(1)) begin
              st_ctl.rd_en = 1'b1;
              rd_idx       = IDX_W'(1);
            end else begin
              res_kind_next = KIND_RELEASE;
              state_next    = S_ONE;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase

    emit_total = is_release ? rel_cnt + TOTAL_W'(1) : rel_cnt;
    if (is_release) rel_cnt_next = rel_cnt + TOTAL_W'(1);
    if (add_credit) credits_next = credit_inc;
    if (cfg_wr) credits_next = {1'b0, max_pending} + CREDIT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      next_exp <= '0;
      credits  <= CREDIT_W'(16);
      count    <= '0;
      rel_cnt  <= '0;
    end else begin
      state    <= state_next;
      next_exp <= next_exp_next;
      credits  <= credits_next;
      count    <= count_next;
      rel_cnt  <= rel_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ins_idx  <= ins_idx_next;
    cur_seq  <= cur_seq_next;
    cur_tag  <= cur_tag_next;
    res_kind <= res_kind_next;
  end

  a_put_has_room: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_PUT |-> count < DEPTH_C)
    else $error("insertion into a full hold store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("new item taken while one is in progress");

  a_drain_in_order: assert property (@(posedge clk) disable iff (rst)
    state == S_DRN_CMP |-> mode && count != '0)
    else $error("drain with empty store or outside in-order mode");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit_valid |-> emit_ok)
    else $error("result beat produced with the output stage full");

endmodule

/* design/in_order_release_reorder_buffer_core.sv */
// ----------------------------------------------------------------------------
// in_order_release_reorder_buffer_core
// Credit-limited reorder buffer releasing sequence-numbered items in order.
// ----------------------------------------------------------------------------
// One item is handled at a time; ready is high only between items. A slot
// request, a pass-through item, a drop, or an in-order item with nothing held
// behind it goes from idle to a single result state that emits its beat. An
// item that goes into an empty hold store is written in the put state; into
// a non-empty one the sequencer first compares it against each held entry
// with a larger number, and against the first entry that is not larger, when
// there is one. The sequencer walks down from the tail through one read port
// and one write port, moving each larger entry up one place. An in-order item
// that unlocks held entries goes out first, and each further release reads
// the next head from the store. Stalls on the result side hold the sequencer.
// There is no clearing pass: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module in_order_release_reorder_buffer_core
  import rob_pkg::*;
#(
  parameter int HOLD_DEPTH = 16,
  parameter int SEQ_BITS   = 32,
  parameter int TAG_BITS   = 16
)(
  input  logic              clk,
  input  logic              rst,
  rob_in_if.sink            in_ch,
  rob_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

  logic                mode;
  logic [3:0]          max_pending_next;
  logic                cfg_wr;
  logic                emit_ok;
  logic                emit_valid;
  logic [KIND_W-1:0]   emit_kind;
  logic [SEQ_BITS-1:0] emit_seq;
  logic [TAG_BITS-1:0] emit_tag;
  logic [TOTAL_W-1:0]  emit_total;
  logic                emit_last;
  st_ctl_t             st_ctl;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic [SEQ_BITS-1:0] wr_seq;
  logic [TAG_BITS-1:0] wr_tag;
  logic [SEQ_BITS-1:0] rd_seq;
  logic [TAG_BITS-1:0] rd_tag;

  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [SEQ_BITS-1:0] out_seq;
  logic [TAG_BITS-1:0] out_tag;
  logic [TOTAL_W-1:0]  out_total;
  logic                out_last;

  rob_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mode             (mode),
    .max_pending_next (max_pending_next),
    .cfg_wr           (cfg_wr)
  );

  rob_seq #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .SEQ_BITS   (SEQ_BITS),
    .TAG_BITS   (TAG_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .command     (in_ch.command),
    .seq_number  (in_ch.seq_number),
    .item_handle (in_ch.item_handle),
    .mode        (mode),
    .max_pending (max_pending_next),
    .cfg_wr      (cfg_wr),
    .emit_ok     (emit_ok),
    .emit_valid  (emit_valid),
    .emit_kind   (emit_kind),
    .emit_seq    (emit_seq),
    .emit_tag    (emit_tag),
    .emit_total  (emit_total),
    .emit_last   (emit_last),
    .st_ctl      (st_ctl),
    .rd_idx      (rd_idx),
    .wr_idx      (wr_idx),
    .wr_seq      (wr_seq),
    .wr_tag      (wr_tag),
    .rd_seq      (rd_seq),
    .rd_tag      (rd_tag)
  );

  rob_store #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .SEQ_BITS   (SEQ_BITS),
    .TAG_BITS   (TAG_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .ctl    (st_ctl),
    .rd_idx (rd_idx),
    .wr_idx (wr_idx),
    .wr_seq (wr_seq),
    .wr_tag (wr_tag),
    .rd_seq (rd_seq),
    .rd_tag (rd_tag)
  );

  // result beat register
  assign emit_ok = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ok) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok && emit_valid) begin
      out_kind  <= emit_kind;
      out_seq   <= emit_seq;
      out_tag   <= emit_tag;
      out_total <= emit_total;
      out_last  <= emit_last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.kind           = out_kind;
  assign out_ch.out_seq        = out_seq;
  assign out_ch.out_handle     = out_tag;
  assign out_ch.released_total = out_total;
  assign out_ch.last           = out_last;

endmodule
